// ===== rtl/hbad_pkg.sv =====
package hbad_pkg;

   localparam int WRAM_BANK_BYTES = 4096;
   localparam int WRAM_BANKS      = 8;
   localparam int WRAM_DEPTH      = WRAM_BANKS * WRAM_BANK_BYTES;
   localparam int WRAM_OFF_W      = $clog2(WRAM_BANK_BYTES);
   localparam int WRAM_BANK_W     = $clog2(WRAM_BANKS);
   localparam int WRAM_ADDR_W     = WRAM_BANK_W + WRAM_OFF_W;
   localparam int IO_DEPTH        = 256;
   localparam int IO_ADDR_W       = $clog2(IO_DEPTH);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_WRAM_BANK_SELECT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_MODE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOT_ROM_MAPPED  = 2'd2;

   localparam logic [2:0] TGT_LOCAL    = 3'd0;
   localparam logic [2:0] TGT_CART     = 3'd1;
   localparam logic [2:0] TGT_VIDEO    = 3'd2;
   localparam logic [2:0] TGT_JOYPAD   = 3'd3;
   localparam logic [2:0] TGT_BOOT     = 3'd4;
   localparam logic [2:0] TGT_UNMAPPED = 3'd5;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic        op;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] target;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      SRC_FIXED,
      SRC_WRAM,
      SRC_IO
   } src_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic access;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

// ===== rtl/handheld_bus_address_decoder_core.sv =====
// Bus address decoder for a handheld console memory map. One access is taken when
// start is high and busy is low. Its result is on rsp_item for a single cycle with
// rsp_strobe high, in the respond state that follows the access state, past the
// request register and the result registers; the receiver cannot stall it, so it
// must be taken then. The next access is taken only once these are done: request capture, the decode
// with the single local RAM access, and the registered result. After reset the
// block stays busy while it zeroes all 32768 bytes of work RAM one byte per cycle;
// configuration writes are taken at any time and are always ready.
module handheld_bus_address_decoder_core
   import hbad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_item,
   output logic                   rsp_strobe,
   output rsp_type                rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   hbad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   hbad_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

// ===== rtl/hbad_ctrl.sv =====
module hbad_ctrl
   import hbad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_strobe
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_ACCESS: begin
            cmd.access = 1'b1;
         end
         ST_RESPOND: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/hbad_datapath.sv =====
module hbad_datapath
   import hbad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  req_type                req_item,
   output rsp_type                rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [2:0] bank_select_ff;
   logic       color_mode_ff;
   logic       boot_mapped_ff;

   req_type req_ff;

   logic [WRAM_ADDR_W-1:0] clr_addr_ff;
   logic [WRAM_ADDR_W-1:0] clr_addr_in;

   logic [7:0] wram_mem_ff [WRAM_DEPTH];
   logic [7:0] io_mem_ff   [IO_DEPTH];
   logic [IO_DEPTH-1:0] io_valid_ff;

   logic [7:0] wram_rd_ff;
   logic [7:0] io_rd_ff;
   logic       io_hit_ff;
   logic [2:0] tgt_ff;
   src_type    src_ff;
   logic [7:0] fixed_ff;

   logic                   is_read;
   logic [2:0]             tgt;
   src_type                src;
   logic [7:0]             fixed_val;
   logic                   wram_local;
   logic                   io_local;
   logic [WRAM_BANK_W-1:0] live_bank;
   logic [WRAM_BANK_W-1:0] bank;
   logic [WRAM_ADDR_W-1:0] wram_addr;
   logic [WRAM_ADDR_W-1:0] wram_waddr;
   logic [7:0]             wram_wdata;
   logic                   wram_we;
   logic                   io_we;
   logic [IO_ADDR_W-1:0]   io_addr;
   logic [15:0]            addr;
   logic [3:0]             top;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_select_ff <= 3'd1;
         color_mode_ff  <= 1'b0;
         boot_mapped_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WRAM_BANK_SELECT: bank_select_ff <= csr_data;
            CSR_COLOR_MODE:       color_mode_ff  <= csr_data[0];
            CSR_BOOT_ROM_MAPPED:  boot_mapped_ff <= csr_data[0];
            default:              bank_select_ff <= bank_select_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
   end

   // clear sweep over work ram
   assign clr_addr_in       = clr_addr_ff + WRAM_ADDR_W'(1);
   assign status.clear_last = (clr_addr_ff == WRAM_ADDR_W'(WRAM_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_en && !status.clear_last) begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      if (!color_mode_ff) begin
         live_bank = WRAM_BANK_W'(1);
      end else if (bank_select_ff == 3'd0) begin
         live_bank = WRAM_BANK_W'(1);
      end else if (int'(bank_select_ff) >= WRAM_BANKS) begin
         live_bank = WRAM_BANK_W'(WRAM_BANKS - 1);
      end else begin
         live_bank = bank_select_ff[WRAM_BANK_W-1:0];
      end
   end

   // address decode
   assign addr    = req_ff.address;
   assign top     = addr[15:12];
   assign is_read = (req_ff.op == OP_READ);
   assign io_addr = addr[IO_ADDR_W-1:0];

   always_comb begin
      tgt        = TGT_LOCAL;
      fixed_val  = 8'hFF;
      wram_local = 1'b0;
      io_local   = 1'b0;
      priority if (is_read && boot_mapped_ff && addr < 16'h0100) begin
         tgt = TGT_BOOT;
      end else if (addr < 16'h8000 || top == 4'hA || top == 4'hB) begin
         tgt = TGT_CART;
      end else if (addr < 16'hA000) begin
         tgt = TGT_VIDEO;
      end else if (addr < 16'hFE00) begin
         wram_local = 1'b1;
      end else if (addr < 16'hFEA0) begin
         tgt = TGT_VIDEO;
      end else if (addr < 16'hFF00) begin
         tgt = TGT_UNMAPPED;
      end else if (addr == 16'hFF00) begin
         tgt = TGT_JOYPAD;
      end else if (addr < 16'hFF04) begin
         tgt       = TGT_UNMAPPED;
         fixed_val = 8'h00;
      end else if (addr < 16'hFF08) begin
         io_local = 1'b1;
      end else if (addr == 16'hFF0F) begin
         io_local = 1'b1;
      end else if (addr < 16'hFF10) begin
         tgt = TGT_UNMAPPED;
      end else if (addr < 16'hFF40) begin
         io_local = 1'b1;
      end else if (addr < 16'hFF6C) begin
         tgt = TGT_VIDEO;
      end else if (addr < 16'hFF80) begin
         tgt = TGT_UNMAPPED;
      end else begin
         io_local = 1'b1;
      end
   end

   always_comb begin
      if (!is_read) begin
         src = SRC_FIXED;
      end else if (wram_local) begin
         src = SRC_WRAM;
      end else if (io_local) begin
         src = SRC_IO;
      end else begin
         src = SRC_FIXED;
      end
   end

   assign bank      = (top == 4'hC || top == 4'hE) ? '0 : live_bank;
   assign wram_addr = {bank, addr[WRAM_OFF_W-1:0]};

   assign wram_we    = cmd.clear_en || (cmd.access && wram_local && !is_read);
   assign wram_waddr = cmd.clear_en ? clr_addr_ff : wram_addr;
   assign wram_wdata = cmd.clear_en ? 8'h00 : req_ff.write_data;
   assign io_we      = cmd.access && io_local && !is_read;

   always_ff @(posedge clock) begin
      if (wram_we) begin
         wram_mem_ff[wram_waddr] <= wram_wdata;
      end
      wram_rd_ff <= wram_mem_ff[wram_addr];
   end

   always_ff @(posedge clock) begin
      if (io_we) begin
         io_mem_ff[io_addr] <= req_ff.write_data;
      end
      io_rd_ff <= io_mem_ff[io_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         io_valid_ff <= '0;
      end else if (io_we) begin
         io_valid_ff[io_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.access) begin
         tgt_ff    <= tgt;
         src_ff    <= src;
         io_hit_ff <= io_valid_ff[io_addr];
         fixed_ff  <= (is_read && tgt == TGT_UNMAPPED) ? fixed_val : 8'h00;
      end
   end

   always_comb begin
      rsp_item.target = tgt_ff;
      unique case (src_ff)
         SRC_WRAM: rsp_item.read_data = wram_rd_ff;
         SRC_IO:   rsp_item.read_data = io_hit_ff ? io_rd_ff : 8'h00;
         default:  rsp_item.read_data = fixed_ff;
      endcase
   end

endmodule

// ===== dv/tb.sv =====
module tb;
   import hbad_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 100000;
   localparam int PHASE_ITEMS = 135;
   localparam int FIXED_SETTINGS = 8;
   localparam int RANDOM_SETTINGS = 4;
   localparam int DIRECTED_ROWS = 25;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic       op;
      logic [15:0] address;
      logic [7:0] write_data;
      logic       typed;
      logic [7:0] read_data;
      logic [2:0] target;
   } directed_row_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] bank_word;
      logic [CSR_DATA_W-1:0] color_word;
      logic [CSR_DATA_W-1:0] boot_word;
   } bus_setting_type;

   typedef struct packed {
      req_type req;
      rsp_type rsp;
   } pending_access_type;

   // reset settings: bank 1, monochrome, boot rom overlaid
   localparam directed_row_type DIRECTED[DIRECTED_ROWS] = '{
      '{OP_READ,  16'h0000, 8'h00, 1'b1, 8'h00, TGT_BOOT},
      '{OP_READ,  16'h00FF, 8'h00, 1'b1, 8'h00, TGT_BOOT},
      '{OP_WRITE, 16'h0000, 8'hFF, 1'b1, 8'h00, TGT_CART},
      '{OP_READ,  16'h7FFF, 8'h00, 1'b1, 8'h00, TGT_CART},
      '{OP_READ,  16'h9FFF, 8'h00, 1'b1, 8'h00, TGT_VIDEO},
      '{OP_READ,  16'hA000, 8'h00, 1'b1, 8'h00, TGT_CART},
      '{OP_WRITE, 16'hC000, 8'hA5, 1'b1, 8'h00, TGT_LOCAL},
      '{OP_READ,  16'hE000, 8'h00, 1'b0, 8'h00, TGT_LOCAL},
      '{OP_WRITE, 16'hD123, 8'h5A, 1'b1, 8'h00, TGT_LOCAL},
      '{OP_READ,  16'hF123, 8'h00, 1'b0, 8'h00, TGT_LOCAL},
      '{OP_READ,  16'hFE9F, 8'h00, 1'b1, 8'h00, TGT_VIDEO},
      '{OP_READ,  16'hFEA0, 8'h00, 1'b1, 8'hFF, TGT_UNMAPPED},
      '{OP_WRITE, 16'hFEFF, 8'h77, 1'b1, 8'h00, TGT_UNMAPPED},
      '{OP_READ,  16'hFF00, 8'h00, 1'b1, 8'h00, TGT_JOYPAD},
      '{OP_READ,  16'hFF01, 8'h00, 1'b1, 8'h00, TGT_UNMAPPED},
      '{OP_WRITE, 16'hFF03, 8'h99, 1'b1, 8'h00, TGT_UNMAPPED},
      '{OP_WRITE, 16'hFF04, 8'h12, 1'b1, 8'h00, TGT_LOCAL},
      '{OP_READ,  16'hFF04, 8'h00, 1'b0, 8'h00, TGT_LOCAL},
      '{OP_READ,  16'hFF0E, 8'h00, 1'b1, 8'hFF, TGT_UNMAPPED},
      '{OP_WRITE, 16'hFF0F, 8'hFF, 1'b1, 8'h00, TGT_LOCAL},
      '{OP_READ,  16'hFF0F, 8'h00, 1'b0, 8'h00, TGT_LOCAL},
      '{OP_READ,  16'hFF3F, 8'h00, 1'b1, 8'h00, TGT_LOCAL},
      '{OP_READ,  16'hFF7F, 8'h00, 1'b1, 8'hFF, TGT_UNMAPPED},
      '{OP_WRITE, 16'hFFFF, 8'h81, 1'b1, 8'h00, TGT_LOCAL},
      '{OP_READ,  16'hFFFF, 8'h00, 1'b0, 8'h00, TGT_LOCAL}
   };

   // extremes first; some words carry upper bits that the one-bit registers drop
   localparam bus_setting_type SETTING_LIST[FIXED_SETTINGS] = '{
      '{3'd0, 3'd1, 3'd0},
      '{3'd7, 3'd1, 3'd1},
      '{3'd5, 3'd0, 3'd0},
      '{3'd3, 3'd7, 3'd6},
      '{3'd2, 3'd6, 3'd1},
      '{3'd6, 3'd1, 3'd0},
      '{3'd4, 3'd1, 3'd1},
      '{3'd1, 3'd1, 3'd0}
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_item;
   logic                   rsp_strobe;
   rsp_type                rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   logic [7:0] wram_mirror [0:WRAM_DEPTH-1];
   logic [7:0] hram_mirror [0:126];
   logic [7:0] timer_mirror [0:3];
   logic [7:0] audio_mirror [0:47];
   logic [7:0] irq_flag_mirror;
   logic [7:0] irq_enable_mirror;
   logic [2:0] cfg_bank_sel;
   logic       cfg_color;
   logic       cfg_boot;

   pending_access_type pending_rsp[$];
   int mismatch_count;
   int read_count;
   int write_count;
   int setting_count;
   int target_count [0:7];

   handheld_bus_address_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_type decode_access(req_type r);
      logic [15:0] a;
      logic [2:0]  bank;
      logic [14:0] widx;
      logic        is_rd;
      rsp_type     o;
      a = r.address;
      is_rd = (r.op == OP_READ);
      bank = !cfg_color ? 3'd1 : (cfg_bank_sel == 3'd0) ? 3'd1 : cfg_bank_sel;
      o.read_data = 8'h00;
      o.target = TGT_LOCAL;
      if (is_rd && cfg_boot && a < 16'h0100) begin
         o.target = TGT_BOOT;
      end else if (a < 16'h8000 || a[15:12] == 4'hA || a[15:12] == 4'hB) begin
         o.target = TGT_CART;
      end else if (a < 16'hA000) begin
         o.target = TGT_VIDEO;
      end else if (a < 16'hFE00) begin
         // bank 0 and its echo are fixed, 0xD000 and 0xF000 follow the live bank
         widx = (a[15:12] == 4'hC || a[15:12] == 4'hE) ? {3'd0, a[11:0]} : {bank, a[11:0]};
         if (is_rd) o.read_data = wram_mirror[widx];
         else wram_mirror[widx] = r.write_data;
      end else if (a < 16'hFEA0) begin
         o.target = TGT_VIDEO;
      end else if (a < 16'hFF00) begin
         o.target = TGT_UNMAPPED;
         if (is_rd) o.read_data = 8'hFF;
      end else if (a == 16'hFF00) begin
         o.target = TGT_JOYPAD;
      end else if (a < 16'hFF04) begin
         // serial port reads as zero
         o.target = TGT_UNMAPPED;
      end else if (a < 16'hFF08) begin
         if (is_rd) o.read_data = timer_mirror[a[1:0]];
         else timer_mirror[a[1:0]] = r.write_data;
      end else if (a == 16'hFF0F) begin
         if (is_rd) o.read_data = irq_flag_mirror;
         else irq_flag_mirror = r.write_data;
      end else if (a < 16'hFF10) begin
         o.target = TGT_UNMAPPED;
         if (is_rd) o.read_data = 8'hFF;
      end else if (a < 16'hFF40) begin
         if (is_rd) o.read_data = audio_mirror[a - 16'hFF10];
         else audio_mirror[a - 16'hFF10] = r.write_data;
      end else if (a < 16'hFF6C) begin
         o.target = TGT_VIDEO;
      end else if (a < 16'hFF80) begin
         o.target = TGT_UNMAPPED;
         if (is_rd) o.read_data = 8'hFF;
      end else if (a < 16'hFFFF) begin
         if (is_rd) o.read_data = hram_mirror[a[6:0]];
         else hram_mirror[a[6:0]] = r.write_data;
      end else begin
         if (is_rd) o.read_data = irq_enable_mirror;
         else irq_enable_mirror = r.write_data;
      end
      return o;
   endfunction

   // weighted toward local stores with a narrow offset pool so reads hit earlier writes
   function automatic req_type random_access();
      req_type     r;
      logic [3:0]  top;
      logic [11:0] off;
      r.op = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
      r.write_data = 8'($urandom_range(0, 255));
      off = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
          : (12'($urandom_range(0, 15)) | (($urandom_range(0, 1) == 1) ? 12'hFF0 : 12'h7F0));
      case ($urandom_range(0, 15))
         0: r.address = 16'($urandom_range(0, 65535));
         1: r.address = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 16'h01FF))
                                                     : 16'($urandom_range(0, 16'h7FFF));
         2: r.address = 16'($urandom_range(16'h8000, 16'hBFFF));
         6: r.address = 16'($urandom_range(16'hFE00, 16'hFEFF));
         7, 8: r.address = 16'($urandom_range(16'hFF00, 16'hFF7F));
         9, 10: r.address = 16'($urandom_range(16'hFF80, 16'hFFFF));
         11: r.address = ($urandom_range(0, 2) == 0) ? 16'hFF0F
                       : ($urandom_range(0, 1) == 1) ? 16'hFFFF
                       : 16'($urandom_range(16'hFF00, 16'hFF07));
         default: begin
            top = 4'hC + 4'($urandom_range(0, 3));
            if (top == 4'hF && off >= 12'hE00) off = off - 12'h200;
            r.address = {top, off};
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic send_access(input req_type r, input logic typed, input rsp_type typed_rsp);
      pending_access_type p;
      @(negedge clock);
      start = 1'b1;
      req_item = r;
      @(posedge clock);
      while (busy) @(posedge clock);
      p.req = r;
      p.rsp = decode_access(r);
      if (typed) p.rsp = typed_rsp;
      pending_rsp.push_back(p);
      if (r.op == OP_READ) read_count++;
      else write_count++;
      target_count[p.rsp.target]++;
   endtask

   task automatic hold_off(input int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic wait_for_drain();
      hold_off(1);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_WRAM_BANK_SELECT: cfg_bank_sel = d;
         CSR_COLOR_MODE:       cfg_color = d[0];
         CSR_BOOT_ROM_MAPPED:  cfg_boot = d[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_setting(input bus_setting_type s);
      write_csr(CSR_WRAM_BANK_SELECT, s.bank_word);
      write_csr(CSR_COLOR_MODE, s.color_word);
      write_csr(CSR_BOOT_ROM_MAPPED, s.boot_word);
      write_csr(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom_range(0, 7)));
      setting_count++;
   endtask

   always @(posedge clock) begin : check_rsp
      pending_access_type p;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction rd=%h tgt=%0d",
                                      rsp_item.read_data, rsp_item.target));
         end else begin
            p = pending_rsp.pop_front();
            if (rsp_item.read_data !== p.rsp.read_data)
               report_mismatch($sformatf("addr %h op %0d read_data %h, want %h", p.req.address,
                                         p.req.op, rsp_item.read_data, p.rsp.read_data));
            if (rsp_item.target !== p.rsp.target)
               report_mismatch($sformatf("addr %h op %0d target %0d, want %0d", p.req.address,
                                         p.req.op, rsp_item.target, p.rsp.target));
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || (csr_valid && csr_ready) || rsp_strobe) idle = 0;
         else idle++;
      end
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("handheld_bus_address_decoder_core: mismatch");
      $finish;
   end

   initial begin : stimulus
      req_type         r;
      rsp_type         t;
      bus_setting_type s;
      logic            dense;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mismatch_count = 0;
      read_count = 0;
      write_count = 0;
      setting_count = 0;
      for (int i = 0; i < 8; i++) target_count[i] = 0;
      for (int i = 0; i < WRAM_DEPTH; i++) wram_mirror[i] = 8'h00;
      for (int i = 0; i < 127; i++) hram_mirror[i] = 8'h00;
      for (int i = 0; i < 4; i++) timer_mirror[i] = 8'h00;
      for (int i = 0; i < 48; i++) audio_mirror[i] = 8'h00;
      irq_flag_mirror = 8'h00;
      irq_enable_mirror = 8'h00;
      cfg_bank_sel = 3'd1;
      cfg_color = 1'b0;
      cfg_boot = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         r.op = DIRECTED[i].op;
         r.address = DIRECTED[i].address;
         r.write_data = DIRECTED[i].write_data;
         t.read_data = DIRECTED[i].read_data;
         t.target = DIRECTED[i].target;
         send_access(r, DIRECTED[i].typed, t);
         hold_off(random_gap());
      end

      for (int ph = 0; ph < FIXED_SETTINGS + RANDOM_SETTINGS; ph++) begin
         wait_for_drain();
         if (ph < FIXED_SETTINGS) begin
            s = SETTING_LIST[ph];
         end else begin
            s.bank_word = CSR_DATA_W'($urandom_range(0, 7));
            s.color_word = CSR_DATA_W'($urandom_range(0, 7));
            s.boot_word = CSR_DATA_W'($urandom_range(0, 7));
         end
         apply_setting(s);
         dense = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_access(random_access(), 1'b0, '0);
            // sender waits out every pending result in the middle of odd phases
            if (ph % 2 == 1 && i == PHASE_ITEMS / 2) wait_for_drain();
            else if (!dense) hold_off(random_gap());
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("covered %0d bus accesses (%0d reads, %0d writes) across %0d bus settings",
               read_count + write_count, read_count, write_count, setting_count + 1);
      $display("by target: local %0d cart %0d video %0d joypad %0d boot %0d unmapped %0d",
               target_count[TGT_LOCAL], target_count[TGT_CART], target_count[TGT_VIDEO],
               target_count[TGT_JOYPAD], target_count[TGT_BOOT], target_count[TGT_UNMAPPED]);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("handheld_bus_address_decoder_core: match");
      end else begin
         $display("handheld_bus_address_decoder_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hbad_pkg.sv
rtl/hbad_ctrl.sv
rtl/hbad_datapath.sv
rtl/handheld_bus_address_decoder_core.sv
dv/tb.sv
